>>> rtl/btn_lpdc_pkg.sv
// Package for the button long-press / double-click detector.
// Types, register indexes and reset values; no dependencies.
package btn_lpdc_pkg;

    localparam int unsigned HoldW = 12;
    localparam int unsigned GapW  = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 12;

    localparam logic [HoldW-1:0] HoldMax = '1;
    localparam logic [GapW-1:0]  GapMax  = '1;

    localparam logic [HoldW-1:0] LongThresholdRst = 12'd250;
    localparam logic [HoldW-1:0] HoldLimitRst     = 12'd1000;
    localparam logic [GapW-1:0]  GapTicksRst      = 8'd25;

    localparam logic [CfgIdxW-1:0] REG_LONG_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_HOLD_LIMIT     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GAP_TICKS      = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HOLD   = 3'd1,
        PH_WREL   = 3'd2,
        PH_GAP    = 3'd3,
        PH_SECOND = 3'd4
    } t_phase;

    typedef struct packed {
        logic pressed;
        logic read_long;
        logic read_double;
    } t_item;

    typedef struct packed {
        logic long_press;
        logic double_click;
    } t_result;

    typedef struct packed {
        logic [HoldW-1:0] long_threshold;
        logic [HoldW-1:0] hold_limit;
        logic [GapW-1:0]  gap_ticks;
    } t_cfg;

endpackage

>>> rtl/button_long_press_double_click.sv
// Top level of the button long-press / double-click detector.
// Uses btn_lpdc_pkg, btn_lpdc_cfg and btn_lpdc_core.
//
//   channel | signals                                    | dir
//   in      | i_in_valid, o_in_ready, i_pressed,         | in
//           | i_read_long, i_read_double                 |
//   out     | o_out_valid, i_out_ready, o_long_press,    | out
//           | o_double_click                             |
//   cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index,     | in
//           | i_cfg_data                                 |
//
// One beat per clock sustained while the output is ready; a beat passes
// the input register, then the state update into the result register.
// Reset clears the state machine, flags and both valid bits; registers
// take their reset values. A stalled output holds its beat while the
// input register still takes one more. Config writes are always ready.
module button_long_press_double_click (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_pressed,
    input  logic                               i_read_long,
    input  logic                               i_read_double,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_long_press,
    output logic                               o_double_click,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [btn_lpdc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [btn_lpdc_pkg::CfgDataW-1:0]  i_cfg_data
);
    import btn_lpdc_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    t_cfg    cfg;
    logic    adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    btn_lpdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    btn_lpdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.pressed     <= i_pressed;
            r_item.read_long   <= i_read_long;
            r_item.read_double <= i_read_double;
        end
        if (adv) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_long_press   = r_result.long_press;
    assign o_double_click = r_result.double_click;

endmodule

>>> rtl/btn_lpdc_cfg.sv
// Configuration register file: long threshold, hold limit, gap length.
// Depends on btn_lpdc_pkg.
module btn_lpdc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [btn_lpdc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [btn_lpdc_pkg::CfgDataW-1:0]  i_cfg_data,
    output btn_lpdc_pkg::t_cfg                 o_cfg
);
    import btn_lpdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_threshold <= LongThresholdRst;
            r_cfg.hold_limit     <= HoldLimitRst;
            r_cfg.gap_ticks      <= GapTicksRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LONG_THRESHOLD: r_cfg.long_threshold <= i_cfg_data[HoldW-1:0];
                REG_HOLD_LIMIT:     r_cfg.hold_limit     <= i_cfg_data[HoldW-1:0];
                REG_GAP_TICKS:      r_cfg.gap_ticks      <= i_cfg_data[GapW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/btn_lpdc_core.sv
// Press/gap state machine, sticky flags and read-and-clear logic.
// Advances one tick per i_step. Depends on btn_lpdc_pkg.
module btn_lpdc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  btn_lpdc_pkg::t_item  i_item,
    input  btn_lpdc_pkg::t_cfg   i_cfg,
    output btn_lpdc_pkg::t_result o_result
);
    import btn_lpdc_pkg::*;

    t_phase           r_phase, n_phase;
    logic [HoldW-1:0] r_hold, n_hold;
    logic [GapW-1:0]  r_gap, n_gap;
    logic             r_prev;
    logic             r_long_flag, n_long_flag;
    logic             r_double_flag, n_double_flag;
    logic             r_long_decided, n_long_decided;
    logic             set_long, set_double;
    logic [HoldW-1:0] hold_inc;
    logic [GapW-1:0]  gap_inc;
    logic             is_long;
    logic             lvl;

    assign lvl      = i_item.pressed;
    assign hold_inc = ((r_hold < i_cfg.hold_limit) && (r_hold != HoldMax)) ?
                      r_hold + 1'b1 : r_hold;
    assign gap_inc  = (r_gap != GapMax) ? r_gap + 1'b1 : r_gap;

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_hold         = r_hold;
        n_gap          = r_gap;
        n_long_decided = r_long_decided;
        set_long       = 1'b0;
        set_double     = 1'b0;
        is_long        = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (lvl && !r_prev) begin
                    n_hold  = {{(HoldW-1){1'b0}}, 1'b1};
                    n_phase = PH_HOLD;
                    if (i_cfg.hold_limit <= {{(HoldW-1){1'b0}}, 1'b1}) begin
                        is_long        = ({{(HoldW-1){1'b0}}, 1'b1} >= i_cfg.long_threshold);
                        set_long       = is_long;
                        n_long_decided = is_long;
                        n_phase        = PH_WREL;
                    end
                end
            end
            PH_HOLD: begin
                if (lvl) begin
                    n_hold = hold_inc;
                    if (hold_inc >= i_cfg.hold_limit) begin
                        is_long        = (hold_inc >= i_cfg.long_threshold);
                        set_long       = is_long;
                        n_long_decided = is_long;
                        n_phase        = PH_WREL;
                    end
                end else begin
                    is_long        = (r_hold >= i_cfg.long_threshold);
                    set_long       = is_long;
                    n_long_decided = is_long;
                    if (is_long) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_gap   = '0;
                        n_phase = PH_GAP;
                    end
                end
            end
            PH_WREL: begin
                if (!lvl) begin
                    if (r_long_decided) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_gap   = '0;
                        n_phase = PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                n_gap = gap_inc;
                if (gap_inc >= i_cfg.gap_ticks) begin
                    n_phase = lvl ? PH_SECOND : PH_IDLE;
                end
            end
            PH_SECOND: begin
                if (!lvl) begin
                    set_double = 1'b1;
                    n_phase    = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // flags and read strobes
    always_comb begin
        n_long_flag           = r_long_flag | set_long;
        n_double_flag         = r_double_flag | set_double;
        o_result.long_press   = 1'b0;
        o_result.double_click = 1'b0;
        if (i_item.read_long) begin
            o_result.long_press = n_long_flag;
            n_long_flag         = 1'b0;
        end
        if (i_item.read_double) begin
            o_result.double_click = n_double_flag;
            n_double_flag         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_hold         <= '0;
            r_gap          <= '0;
            r_prev         <= 1'b0;
            r_long_flag    <= 1'b0;
            r_double_flag  <= 1'b0;
            r_long_decided <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_hold         <= n_hold;
            r_gap          <= n_gap;
            r_prev         <= lvl;
            r_long_flag    <= n_long_flag;
            r_double_flag  <= n_double_flag;
            r_long_decided <= n_long_decided;
        end
    end

endmodule
